>>> rtl/sbwg_pkg.sv
// ----------------------------------------------------------------------------
// sbwg_pkg
// Shared types, widths and codes of the spectral bin Wiener gain unit.
// ----------------------------------------------------------------------------
package sbwg_pkg;

  // Number of start frames gathered before the noise estimate is seeded.
  localparam int START_FRAMES = 10;
  localparam int BUF_DEPTH    = 16;
  localparam int IDX_W        = $clog2(BUF_DEPTH);
  localparam int CNT_W        = $clog2(BUF_DEPTH + 1);

  // Field widths.
  localparam int PWR_W   = 16;
  localparam int WGT_W   = 16;
  localparam int FLOOR_W = 17;
  localparam int CFG_W   = 17;
  localparam int ADDR_W  = 2;

  // Divider widths.
  localparam int DVD_W  = 48;
  localparam int DVS_W  = 33;
  localparam int STEP_W = $clog2(DVD_W + 1);

  // Fixed-point constants.
  localparam logic [WGT_W-1:0] ONE_Q15 = 16'd32768;
  localparam logic [32:0]      ONE_Q16 = 33'd65536;

  // Register indexes.
  localparam logic [ADDR_W-1:0] REG_NOISE_SMOOTHING = 2'd0;
  localparam logic [ADDR_W-1:0] REG_SNR_SMOOTHING   = 2'd1;
  localparam logic [ADDR_W-1:0] REG_SNR_FLOOR       = 2'd2;

  // Reset values of the registers.
  localparam logic [WGT_W-1:0]   RST_NOISE_SMOOTHING = 16'd31130;
  localparam logic [WGT_W-1:0]   RST_SNR_SMOOTHING   = 16'd32113;
  localparam logic [FLOOR_W-1:0] RST_SNR_FLOOR       = 17'd5206;

  // Datapath operation codes.
  typedef logic [4:0] op_t;
  localparam op_t OP_NONE      = 5'd0;
  localparam op_t OP_ACCEPT    = 5'd1;
  localparam op_t OP_DIV_INIT  = 5'd2;
  localparam op_t OP_WAIT_INIT = 5'd3;
  localparam op_t OP_RD        = 5'd4;
  localparam op_t OP_LD        = 5'd5;
  localparam op_t OP_SQ        = 5'd6;
  localparam op_t OP_MIXN      = 5'd7;
  localparam op_t OP_NOISE     = 5'd8;
  localparam op_t OP_PASS      = 5'd9;
  localparam op_t OP_DIV_POST  = 5'd10;
  localparam op_t OP_WAIT_POST = 5'd11;
  localparam op_t OP_DIV_PRIOR = 5'd12;
  localparam op_t OP_WAIT_PRIO = 5'd13;
  localparam op_t OP_MIXS      = 5'd14;
  localparam op_t OP_SNR       = 5'd15;
  localparam op_t OP_DIV_GAIN  = 5'd16;
  localparam op_t OP_WAIT_GAIN = 5'd17;
  localparam op_t OP_GAIN      = 5'd18;
  localparam op_t OP_EMIT      = 5'd19;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic running;
    logic gather_done;
    logic noise_zero;
    logic div_done;
    logic out_free;
    logic more;
  } status_t;

  // Saturate a 48-bit value to 32 bits.
  function automatic logic [31:0] sat32(input logic [47:0] v);
    logic [31:0] r;
    r = (v[47:32] != 16'd0) ? 32'hFFFF_FFFF : v[31:0];
    return r;
  endfunction

  // Clamp a Q1.15 weight at one.
  function automatic logic [WGT_W-1:0] clamp_w(input logic [WGT_W-1:0] w);
    logic [WGT_W-1:0] r;
    r = (w > ONE_Q15) ? ONE_Q15 : w;
    return r;
  endfunction

endpackage

>>> rtl/sbwg_div.sv
// ----------------------------------------------------------------------------
// sbwg_div
// Restoring divider, one quotient bit per cycle over the full dividend.
// ----------------------------------------------------------------------------
module sbwg_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [sbwg_pkg::DVD_W-1:0] dividend,
  input  logic [sbwg_pkg::DVS_W-1:0] divisor,
  output logic                       done,
  output logic [sbwg_pkg::DVD_W-1:0] quotient
);

  logic [sbwg_pkg::DVS_W-1:0]  rem_r, rem_nxt;
  logic [sbwg_pkg::DVD_W-1:0]  quo_r, quo_nxt;
  logic [sbwg_pkg::DVS_W-1:0]  dvs_r;
  logic [sbwg_pkg::STEP_W-1:0] cnt_r, cnt_nxt;
  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [sbwg_pkg::DVS_W:0]    trial;
  logic                        fits;

  // One trial subtraction per cycle.
  always_comb begin
    trial    = {rem_r, quo_r[sbwg_pkg::DVD_W-1]};
    fits     = (trial >= {1'b0, dvs_r});
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? sbwg_pkg::DVS_W'(trial - {1'b0, dvs_r})
                     : trial[sbwg_pkg::DVS_W-1:0];
      quo_nxt = {quo_r[sbwg_pkg::DVD_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == sbwg_pkg::STEP_W'(sbwg_pkg::DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Operand and working registers.
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> rtl/sbwg_ctrl.sv
// ----------------------------------------------------------------------------
// sbwg_ctrl
// Sequencer that steps the datapath through gathering, seeding and filtering.
// ----------------------------------------------------------------------------
module sbwg_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  sbwg_pkg::status_t st,
  output sbwg_pkg::cmd_t    cmd
);

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_DECIDE = 5'd1;
  localparam logic [4:0] ST_DINIT  = 5'd2;
  localparam logic [4:0] ST_WINIT  = 5'd3;
  localparam logic [4:0] ST_RD     = 5'd4;
  localparam logic [4:0] ST_LD     = 5'd5;
  localparam logic [4:0] ST_SQ     = 5'd6;
  localparam logic [4:0] ST_MIXN   = 5'd7;
  localparam logic [4:0] ST_NOISE  = 5'd8;
  localparam logic [4:0] ST_CHK    = 5'd9;
  localparam logic [4:0] ST_WPOST  = 5'd10;
  localparam logic [4:0] ST_DPRIO  = 5'd11;
  localparam logic [4:0] ST_WPRIO  = 5'd12;
  localparam logic [4:0] ST_MIXS   = 5'd13;
  localparam logic [4:0] ST_SNR    = 5'd14;
  localparam logic [4:0] ST_DGAIN  = 5'd15;
  localparam logic [4:0] ST_WGAIN  = 5'd16;
  localparam logic [4:0] ST_GAIN   = 5'd17;
  localparam logic [4:0] ST_EMIT   = 5'd18;

  logic [4:0] state_r, state_nxt;

  assign in_tready = (state_r == ST_IDLE);

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd.op    = sbwg_pkg::OP_NONE;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.op    = sbwg_pkg::OP_ACCEPT;
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (st.running) begin
          state_nxt = ST_SQ;
        end else if (st.gather_done) begin
          state_nxt = ST_DINIT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DINIT: begin
        cmd.op    = sbwg_pkg::OP_DIV_INIT;
        state_nxt = ST_WINIT;
      end
      ST_WINIT: begin
        cmd.op = sbwg_pkg::OP_WAIT_INIT;
        if (st.div_done) begin
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        cmd.op    = sbwg_pkg::OP_RD;
        state_nxt = ST_LD;
      end
      ST_LD: begin
        cmd.op    = sbwg_pkg::OP_LD;
        state_nxt = ST_SQ;
      end
      ST_SQ: begin
        cmd.op    = sbwg_pkg::OP_SQ;
        state_nxt = ST_MIXN;
      end
      ST_MIXN: begin
        cmd.op    = sbwg_pkg::OP_MIXN;
        state_nxt = ST_NOISE;
      end
      ST_NOISE: begin
        cmd.op    = sbwg_pkg::OP_NOISE;
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        if (st.noise_zero) begin
          cmd.op    = sbwg_pkg::OP_PASS;
          state_nxt = ST_EMIT;
        end else begin
          cmd.op    = sbwg_pkg::OP_DIV_POST;
          state_nxt = ST_WPOST;
        end
      end
      ST_WPOST: begin
        cmd.op = sbwg_pkg::OP_WAIT_POST;
        if (st.div_done) begin
          state_nxt = ST_DPRIO;
        end
      end
      ST_DPRIO: begin
        cmd.op    = sbwg_pkg::OP_DIV_PRIOR;
        state_nxt = ST_WPRIO;
      end
      ST_WPRIO: begin
        cmd.op = sbwg_pkg::OP_WAIT_PRIO;
        if (st.div_done) begin
          state_nxt = ST_MIXS;
        end
      end
      ST_MIXS: begin
        cmd.op    = sbwg_pkg::OP_MIXS;
        state_nxt = ST_SNR;
      end
      ST_SNR: begin
        cmd.op    = sbwg_pkg::OP_SNR;
        state_nxt = ST_DGAIN;
      end
      ST_DGAIN: begin
        cmd.op    = sbwg_pkg::OP_DIV_GAIN;
        state_nxt = ST_WGAIN;
      end
      ST_WGAIN: begin
        cmd.op = sbwg_pkg::OP_WAIT_GAIN;
        if (st.div_done) begin
          state_nxt = ST_GAIN;
        end
      end
      ST_GAIN: begin
        cmd.op    = sbwg_pkg::OP_GAIN;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (st.out_free) begin
          cmd.op    = sbwg_pkg::OP_EMIT;
          state_nxt = st.more ? ST_RD : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/sbwg_dp.sv
// ----------------------------------------------------------------------------
// sbwg_dp
// Datapath: configuration, series state, start buffer, arithmetic and the
// output register.
// ----------------------------------------------------------------------------
module sbwg_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  sbwg_pkg::cmd_t                   cmd,
  output sbwg_pkg::status_t                st,
  input  logic                             cfg_we,
  input  logic [sbwg_pkg::ADDR_W-1:0]      cfg_addr,
  input  logic [sbwg_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic [sbwg_pkg::PWR_W-1:0]       in_power,
  input  logic                             in_last,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [sbwg_pkg::PWR_W-1:0]       out_power,
  output logic                             out_last
);

  // Configuration registers.
  logic [sbwg_pkg::WGT_W-1:0]   alpha_r, beta_r;
  logic [sbwg_pkg::FLOOR_W-1:0] floor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= sbwg_pkg::RST_NOISE_SMOOTHING;
      beta_r  <= sbwg_pkg::RST_SNR_SMOOTHING;
      floor_r <= sbwg_pkg::RST_SNR_FLOOR;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        sbwg_pkg::REG_NOISE_SMOOTHING: alpha_r <= cfg_wdata[sbwg_pkg::WGT_W-1:0];
        sbwg_pkg::REG_SNR_SMOOTHING:   beta_r  <= cfg_wdata[sbwg_pkg::WGT_W-1:0];
        sbwg_pkg::REG_SNR_FLOOR:       floor_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Series state.
  logic                         running_r, replay_r, last_r, gdone_r;
  logic [sbwg_pkg::CNT_W-1:0]   count_r;
  logic [sbwg_pkg::IDX_W-1:0]   idx_r;
  logic [36:0]                  sum_r;
  logic [31:0]                  noise_r;
  logic [sbwg_pkg::PWR_W-1:0]   prev_r;

  // Working registers.
  logic [sbwg_pkg::PWR_W-1:0]   p_r, rdata_r, res_r;
  logic [31:0]                  o_r, prev2_r, post_r, prior_r, snr_r;
  logic [47:0]                  ta_r, tb_r;
  logic [sbwg_pkg::PWR_W-1:0]   gain_r;

  // Output register.
  logic                         ov_r;
  logic [sbwg_pkg::PWR_W-1:0]   opwr_r;
  logic                         olast_r;

  // Start buffer.
  logic [sbwg_pkg::PWR_W-1:0]   buf_mem [sbwg_pkg::BUF_DEPTH];

  // Divider.
  logic                         div_start;
  logic [sbwg_pkg::DVD_W-1:0]   div_dvd, div_q;
  logic [sbwg_pkg::DVS_W-1:0]   div_dvs;
  logic                         div_done;

  logic [sbwg_pkg::WGT_W-1:0]   a_w, b_w;
  logic [48:0]                  mix_sum;
  logic [33:0]                  mix_shr;
  logic [31:0]                  mix_sat, f_val, snr_cl;
  logic [sbwg_pkg::CNT_W-1:0]   cnt_inc;
  logic                         more;
  logic [31:0]                  gprod;
  logic [31:0]                  in_sq;

  assign a_w     = sbwg_pkg::clamp_w(alpha_r);
  assign b_w     = sbwg_pkg::clamp_w(beta_r);
  assign mix_sum = {1'b0, ta_r} + {1'b0, tb_r};
  assign mix_shr = mix_sum[48:15];
  assign mix_sat = (mix_shr[33:32] != 2'd0) ? 32'hFFFF_FFFF : mix_shr[31:0];
  assign f_val   = (post_r > 32'd65536) ? post_r - 32'd65536 : 32'd0;
  assign snr_cl  = (mix_sat < {15'd0, floor_r}) ? {15'd0, floor_r} : mix_sat;
  assign cnt_inc = count_r + 1'b1;
  assign more    = replay_r && (({1'b0, idx_r} + 1'b1) < count_r);
  assign gprod   = gain_r * p_r;
  assign in_sq   = in_power * in_power;

  // Divider operand selection.
  always_comb begin
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    case (cmd.op)
      sbwg_pkg::OP_DIV_INIT: begin
        div_start = 1'b1;
        div_dvd   = {11'd0, sum_r};
        div_dvs   = {28'd0, count_r};
      end
      sbwg_pkg::OP_DIV_POST: begin
        div_start = 1'b1;
        div_dvd   = {o_r, 16'd0};
        div_dvs   = {1'b0, noise_r};
      end
      sbwg_pkg::OP_DIV_PRIOR: begin
        div_start = 1'b1;
        div_dvd   = {prev2_r, 16'd0};
        div_dvs   = {1'b0, noise_r};
      end
      sbwg_pkg::OP_DIV_GAIN: begin
        div_start = 1'b1;
        div_dvd   = {snr_r, 16'd0};
        div_dvs   = {1'b0, snr_r} + sbwg_pkg::ONE_Q16;
      end
      default: ;
    endcase
  end

  sbwg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  // Buffer write on a gathering transfer, registered read on replay.
  always_ff @(posedge clk) begin
    if (cmd.op == sbwg_pkg::OP_ACCEPT && !running_r) begin
      buf_mem[count_r[sbwg_pkg::IDX_W-1:0]] <= in_power;
    end
    if (cmd.op == sbwg_pkg::OP_RD) begin
      rdata_r <= buf_mem[idx_r];
    end
  end

  // Control state of the series.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      replay_r  <= 1'b0;
      count_r   <= '0;
      idx_r     <= '0;
      sum_r     <= '0;
      noise_r   <= '0;
      prev_r    <= '0;
      ov_r      <= 1'b0;
    end else begin
      if (cmd.op == sbwg_pkg::OP_EMIT) begin
        ov_r <= 1'b1;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
      case (cmd.op)
        sbwg_pkg::OP_ACCEPT: begin
          if (!running_r) begin
            count_r <= cnt_inc;
            sum_r   <= sum_r + {5'd0, in_sq};
          end
        end
        sbwg_pkg::OP_WAIT_INIT: begin
          if (div_done) begin
            noise_r  <= sbwg_pkg::sat32(div_q);
            replay_r <= 1'b1;
            idx_r    <= '0;
          end
        end
        sbwg_pkg::OP_NOISE: begin
          noise_r <= mix_sat;
        end
        sbwg_pkg::OP_EMIT: begin
          if (more) begin
            prev_r <= res_r;
            idx_r  <= idx_r + 1'b1;
          end else if (last_r) begin
            running_r <= 1'b0;
            replay_r  <= 1'b0;
            count_r   <= '0;
            sum_r     <= '0;
            noise_r   <= '0;
            prev_r    <= '0;
          end else begin
            prev_r <= res_r;
            if (replay_r) begin
              replay_r  <= 1'b0;
              running_r <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Arithmetic steps; each command registers its products, its division result or its loaded value.
  always_ff @(posedge clk) begin
    case (cmd.op)
      sbwg_pkg::OP_ACCEPT: begin
        last_r  <= in_last;
        p_r     <= in_power;
        gdone_r <= (cnt_inc >= sbwg_pkg::CNT_W'(sbwg_pkg::START_FRAMES)) || in_last;
      end
      sbwg_pkg::OP_LD: begin
        p_r <= rdata_r;
      end
      sbwg_pkg::OP_SQ: begin
        o_r     <= p_r * p_r;
        prev2_r <= prev_r * prev_r;
      end
      sbwg_pkg::OP_MIXN: begin
        ta_r <= a_w * noise_r;
        tb_r <= (sbwg_pkg::ONE_Q15 - a_w) * o_r;
      end
      sbwg_pkg::OP_PASS: begin
        res_r <= p_r;
      end
      sbwg_pkg::OP_WAIT_POST: begin
        if (div_done) begin
          post_r <= sbwg_pkg::sat32(div_q);
        end
      end
      sbwg_pkg::OP_WAIT_PRIO: begin
        if (div_done) begin
          prior_r <= sbwg_pkg::sat32(div_q);
        end
      end
      sbwg_pkg::OP_MIXS: begin
        ta_r <= b_w * prior_r;
        tb_r <= (sbwg_pkg::ONE_Q15 - b_w) * f_val;
      end
      sbwg_pkg::OP_SNR: begin
        snr_r <= snr_cl;
      end
      sbwg_pkg::OP_WAIT_GAIN: begin
        if (div_done) begin
          gain_r <= div_q[sbwg_pkg::PWR_W-1:0];
        end
      end
      sbwg_pkg::OP_GAIN: begin
        res_r <= gprod[31:16];
      end
      sbwg_pkg::OP_EMIT: begin
        opwr_r  <= res_r;
        olast_r <= last_r && !more;
      end
      default: ;
    endcase
  end

  // Status back to the sequencer.
  always_comb begin
    st.running     = running_r;
    st.gather_done = gdone_r;
    st.noise_zero  = (noise_r == 32'd0);
    st.div_done    = div_done;
    st.out_free    = !ov_r || out_tready;
    st.more        = more;
  end

  assign out_tvalid = ov_r;
  assign out_power  = opwr_r;
  assign out_last   = olast_r;

  // A result is loaded only into a free output register.
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == sbwg_pkg::OP_EMIT |-> (!ov_r || out_tready))
    else $error("result loaded over a pending transfer");

  // The gathered count never passes the start length.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= sbwg_pkg::CNT_W'(sbwg_pkg::START_FRAMES))
    else $error("start count out of range");

  // Replay reads only entries written in this series.
  a_replay_idx: assert property (@(posedge clk) disable iff (!rst_n)
    replay_r |-> ({1'b0, idx_r} < count_r))
    else $error("replay index beyond gathered frames");

  // Replay and running phase never overlap.
  a_phase: assert property (@(posedge clk) disable iff (!rst_n)
    replay_r |-> !running_r)
    else $error("replay while running");

endmodule

>>> rtl/spectral_bin_wiener_gain_unit.sv
// ----------------------------------------------------------------------------
// spectral_bin_wiener_gain_unit
// Decision-directed Wiener gain for one spectral bin, series after series.
// ----------------------------------------------------------------------------
// Usage: each input transfer carries one frame's bin power; the first ten
// frames of a series (or fewer, if tlast comes earlier) only gather and give
// no output, after which the gathered frames are filtered and sent as a burst,
// and every later frame gives one output. A filtered frame runs three 48-step
// divisions in the one shared one-bit-per-cycle divider plus the multiply and
// control steps; a frame whose noise estimate is zero skips the divisions.
// Seeding the noise estimate adds one more division. Input is taken only
// between frames, while a finished result may still wait in the output
// register. Registers are to be written only while the unit is idle; the
// unit itself does not enforce this.
module spectral_bin_wiener_gain_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [15:0]                   in_tdata,   // [15:0] bin_power
  input  logic                          in_tlast,   // series_end
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [15:0]                   out_tdata,  // [15:0] filtered_power
  output logic                          out_tlast,  // series_last
  input  logic                          cfg_we,
  input  logic [sbwg_pkg::ADDR_W-1:0]   cfg_addr,
  input  logic [sbwg_pkg::CFG_W-1:0]    cfg_wdata
);

  sbwg_pkg::cmd_t    cmd;
  sbwg_pkg::status_t st;

  sbwg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  sbwg_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_power   (in_tdata),
    .in_last    (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_power  (out_tdata),
    .out_last   (out_tlast)
  );

endmodule

>>> dv/tb_spectral_bin_wiener_gain_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_spectral_bin_wiener_gain_unit
// Self-checking bench for the spectral bin Wiener gain unit. Bin series are
// queued per phase, each phase under its own register setting. A bit-accurate
// predictor runs on every accepted input transfer and expected results are
// compared in order with every accepted output transfer. Both sides idle at
// random, except during the quiet phases.
// ----------------------------------------------------------------------------
module tb_spectral_bin_wiener_gain_unit;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 400;
  localparam int GATHER_LEN     = sbwg_pkg::START_FRAMES;

  typedef struct packed {
    logic [15:0] pwr;
    logic        last;
  } frame_t;

  logic                        clk;
  logic                        rst_n;
  logic                        in_tvalid;
  logic                        in_tready;
  logic [15:0]                 in_tdata;
  logic                        in_tlast;
  logic                        out_tvalid;
  logic                        out_tready;
  logic [15:0]                 out_tdata;
  logic                        out_tlast;
  logic                        cfg_we;
  logic [sbwg_pkg::ADDR_W-1:0] cfg_addr;
  logic [sbwg_pkg::CFG_W-1:0]  cfg_wdata;

  frame_t pending_frames[$];
  frame_t expected_power[$];
  int     mismatch_count;
  int     idle_cycles;
  int     frames_queued;
  int     phase_idx;
  logic   quiet;
  logic   in_taken;

  // Predictor copy of the registers and the per-series state.
  logic [15:0] alpha_reg, beta_reg;
  logic [16:0] floor_reg;
  logic [31:0] noise_est;
  logic [15:0] prev_out;
  logic [15:0] gather_buf[16];
  int          gather_cnt;
  logic [63:0] energy_sum;
  logic        filtering;

  spectral_bin_wiener_gain_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic logic [63:0] sat_u32(input logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
  endfunction

  // Filters one power value and updates the noise estimate and previous output.
  function automatic logic [15:0] wiener_filter(input logic [15:0] p);
    logic [63:0] o, a, b, n, post, excess, prior, snr, gain;
    logic [15:0] res;
    o = 64'(p) * 64'(p);
    a = (alpha_reg > 16'd32768) ? 64'd32768 : 64'(alpha_reg);
    b = (beta_reg > 16'd32768) ? 64'd32768 : 64'(beta_reg);
    n = (a * 64'(noise_est) + (64'd32768 - a) * o) >> 15;
    res = p;
    noise_est = n[31:0];
    if (n != 0) begin
      post   = sat_u32((o << 16) / n);
      excess = (post > 64'd65536) ? post - 64'd65536 : 64'd0;
      prior  = sat_u32(((64'(prev_out) * 64'(prev_out)) << 16) / n);
      snr    = sat_u32((b * prior + (64'd32768 - b) * excess) >> 15);
      if (snr < 64'(floor_reg)) snr = 64'(floor_reg);
      gain = (snr << 16) / (snr + 64'd65536);
      res  = 16'((gain * 64'(p)) >> 16);
    end
    prev_out = res;
    return res;
  endfunction

  // Advances the predictor by one accepted frame and queues its results.
  function automatic void predict_frame(input frame_t f);
    frame_t r;
    logic [63:0] seed;
    if (filtering) begin
      r.pwr  = wiener_filter(f.pwr);
      r.last = f.last;
      expected_power.push_back(r);
    end else begin
      gather_buf[gather_cnt] = f.pwr;
      gather_cnt++;
      energy_sum += 64'(f.pwr) * 64'(f.pwr);
      if (gather_cnt >= GATHER_LEN || f.last) begin
        seed      = sat_u32(energy_sum / 64'(gather_cnt));
        noise_est = seed[31:0];
        for (int i = 0; i < gather_cnt; i++) begin
          r.pwr  = wiener_filter(gather_buf[i]);
          r.last = f.last && (i == gather_cnt - 1);
          expected_power.push_back(r);
        end
        filtering = 1'b1;
      end
    end
    if (f.last) begin
      noise_est  = '0;
      prev_out   = '0;
      gather_cnt = 0;
      energy_sum = '0;
      filtering  = 1'b0;
    end
  endfunction

  // Input side: accepted transfers feed the predictor.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      predict_frame(pending_frames.pop_front());
      in_taken <= 1'b1;
    end else begin
      in_taken <= 1'b0;
    end
  end

  // Driver: presents the oldest pending frame, holding it until the transfer.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (pending_frames.size() != 0 && (quiet || $urandom_range(0, 99) >= 17)) begin
        in_tvalid <= 1'b1;
        in_tdata  <= pending_frames[0].pwr;
        in_tlast  <= pending_frames[0].last;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    out_tready <= quiet || ($urandom_range(0, 99) >= 17);
  end

  // Monitor: every output transfer is checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_power.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("Unexpected result: power %0d last %0b", out_tdata, out_tlast);
      end else begin
        if (out_tdata !== expected_power[0].pwr || out_tlast !== expected_power[0].last) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Mismatch: expected power %0d last %0b, got power %0d last %0b",
                     expected_power[0].pwr, expected_power[0].last, out_tdata, out_tlast);
        end
        void'(expected_power.pop_front());
      end
    end
  end

  // Watchdog: counts cycles without any transfer or register write.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input logic [sbwg_pkg::ADDR_W-1:0] addr,
                           input logic [sbwg_pkg::CFG_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (addr)
      sbwg_pkg::REG_NOISE_SMOOTHING: alpha_reg = value[15:0];
      sbwg_pkg::REG_SNR_SMOOTHING:   beta_reg  = value[15:0];
      sbwg_pkg::REG_SNR_FLOOR:       floor_reg = value;
      default: ;
    endcase
  endtask

  task automatic set_regs(input int alpha, input int beta, input int flr);
    write_reg(sbwg_pkg::REG_NOISE_SMOOTHING, sbwg_pkg::CFG_W'(alpha));
    write_reg(sbwg_pkg::REG_SNR_SMOOTHING, sbwg_pkg::CFG_W'(beta));
    write_reg(sbwg_pkg::REG_SNR_FLOOR, sbwg_pkg::CFG_W'(flr));
  endtask

  // Power values weighted toward the extremes and toward small magnitudes.
  function automatic logic [15:0] pick_power();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_series(input int len, input int kind);
    frame_t f;
    for (int i = 0; i < len; i++) begin
      case (kind)
        0: f.pwr = pick_power();
        1: f.pwr = 16'd0;
        2: f.pwr = 16'hFFFF;
        default: f.pwr = (i % 2) ? 16'hFFFF : 16'd0;
      endcase
      f.last = (i == len - 1);
      pending_frames.push_back(f);
      frames_queued++;
    end
  endtask

  // Waits until every queued frame is taken and every result has arrived.
  task automatic drain();
    while (pending_frames.size() != 0 || expected_power.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic int pick_weight();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 32768;
      2: return $urandom_range(32769, 65535);
      default: return $urandom_range(28000, 32767);
    endcase
  endfunction

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tlast       = 1'b0;
    out_tready     = 1'b0;
    cfg_we         = 1'b0;
    cfg_addr       = '0;
    cfg_wdata      = '0;
    quiet          = 1'b0;
    in_taken       = 1'b0;
    mismatch_count = 0;
    idle_cycles    = 0;
    frames_queued  = 0;
    phase_idx      = 0;
    alpha_reg      = sbwg_pkg::RST_NOISE_SMOOTHING;
    beta_reg       = sbwg_pkg::RST_SNR_SMOOTHING;
    floor_reg      = sbwg_pkg::RST_SNR_FLOOR;
    noise_est      = '0;
    prev_out       = '0;
    gather_cnt     = 0;
    energy_sum     = '0;
    filtering      = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: reset settings; all-zero series passes through, short series,
    // a single frame, full-scale frames and a series past the gather length.
    queue_series(12, 1);
    queue_series(3, 0);
    queue_series(1, 2);
    queue_series(5, 3);
    drain();
    set_regs(0, 0, 0);
    queue_series(4, 2);
    drain();
    set_regs(65535, 65535, 65536);
    queue_series(3, 3);
    drain();
    set_regs(32768, 32768, 131071);
    queue_series(4, 0);
    drain();

    // Random: mostly full series past the gather stage, some short ones.
    // The first random phase always runs without idling.
    while (frames_queued < 430) begin
      quiet = (phase_idx == 0) || ($urandom_range(0, 4) == 0);
      phase_idx++;
      if ($urandom_range(0, 3) == 0)
        set_regs(sbwg_pkg::RST_NOISE_SMOOTHING, sbwg_pkg::RST_SNR_SMOOTHING,
                 sbwg_pkg::RST_SNR_FLOOR);
      else
        set_regs(pick_weight(), pick_weight(),
                 $urandom_range(0, 1) ? $urandom_range(0, 65536) : $urandom_range(0, 131071));
      for (int s = 0; s < 3; s++)
        queue_series(($urandom_range(0, 4) == 0) ? $urandom_range(1, 9)
                                                 : $urandom_range(10, 24), 0);
      drain();
    end
    quiet = 1'b0;

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
